// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions in the motion wake detector.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is high.
`define MWD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("motion wake detector assertion failed");

// Check a property on every rising edge, reset included.
`define MWD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("motion wake detector assertion failed");

`endif

// ===== hw/rtl/mwd_pkg.sv =====
// ----------------------------------------------------------------------------
// mwd_pkg
// Types, codes and constants shared by the motion wake detector modules.
// ----------------------------------------------------------------------------
package mwd_pkg;

  localparam int ACCEL_FRAC_BITS = 12;
  localparam int SHAKE_MIN_HITS  = 3;

  localparam logic [16:0] ONE_G    = 17'(1 << ACCEL_FRAC_BITS);
  localparam logic [39:0] ONE_G_SQ = 40'(1) << (2 * ACCEL_FRAC_BITS);
  localparam logic [39:0] TINY_MUL = 40'd100;
  localparam logic [3:0]  CNT_MAX  = 4'd15;
  localparam logic [3:0]  SHAKE_HITS = 4'(SHAKE_MIN_HITS);
  localparam logic [8:0]  ALPHA_MAX = 9'd256;

  localparam logic [2:0] REG_ENABLE     = 3'd0;
  localparam logic [2:0] REG_ARM_DELAY  = 3'd1;
  localparam logic [2:0] REG_POLL       = 3'd2;
  localparam logic [2:0] REG_ALPHA      = 3'd3;
  localparam logic [2:0] REG_TILT_THR   = 3'd4;
  localparam logic [2:0] REG_TILT_HOLD  = 3'd5;
  localparam logic [2:0] REG_SHAKE_THR  = 3'd6;
  localparam logic [2:0] REG_SHAKE_WIN  = 3'd7;

  localparam logic [1:0] CAUSE_NONE  = 2'd0;
  localparam logic [1:0] CAUSE_TILT  = 2'd1;
  localparam logic [1:0] CAUSE_SHAKE = 2'd2;

  localparam logic [3:0] STEP_DIFF   = 4'd0;
  localparam logic [3:0] STEP_AA     = 4'd1;
  localparam logic [3:0] STEP_FF     = 4'd2;
  localparam logic [3:0] STEP_RR     = 4'd3;
  localparam logic [3:0] STEP_FR     = 4'd4;
  localparam logic [3:0] STEP_DOT    = 4'd5;
  localparam logic [3:0] STEP_RC     = 4'd6;
  localparam logic [3:0] STEP_DD     = 4'd7;
  localparam logic [3:0] STEP_PLO    = 4'd8;
  localparam logic [3:0] STEP_PHI    = 4'd9;
  localparam logic [3:0] STEP_HI     = 4'd10;
  localparam logic [3:0] STEP_LO     = 4'd11;
  localparam logic [3:0] STEP_DECIDE = 4'd12;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_DONE = 3'b100
  } state_t;

  typedef enum logic [2:0] {
    LOP_DIFF,
    LOP_AA,
    LOP_FF,
    LOP_RR,
    LOP_FR
  } lane_op_t;

  typedef struct packed {
    logic     load;
    logic     capture;
    logic     upd;
    lane_op_t op;
  } lane_cmd_t;

  typedef struct packed {
    logic       run;
    logic [3:0] step;
  } calc_ctl_t;

  typedef struct packed {
    logic big;
    logic tilted;
    logic dev;
  } merge_flags_t;

endpackage

// ===== hw/rtl/mwd_lane.sv =====
// ----------------------------------------------------------------------------
// mwd_lane
// One axis: holds sample, filtered and reference values, one multiplier.
// ----------------------------------------------------------------------------
module mwd_lane (
  input  logic                     clk,
  input  mwd_pkg::lane_cmd_t       cmd,
  input  logic signed [15:0]       accel,
  input  logic        [8:0]        alpha,
  output logic signed [33:0]       prod
);

  logic signed [15:0] a_r;
  logic signed [15:0] filt;
  logic signed [15:0] ref_v;
  logic signed [15:0] filt_next;
  logic signed [16:0] opa;
  logic signed [16:0] opb;

  assign filt_next = filt + $signed(prod[23:8]);

  always_comb begin
    unique case (cmd.op)
      mwd_pkg::LOP_DIFF: begin
        opa = 17'(a_r) - 17'(filt);
        opb = $signed({8'b0, alpha});
      end
      mwd_pkg::LOP_AA: begin
        opa = 17'(a_r);
        opb = 17'(a_r);
      end
      mwd_pkg::LOP_FF: begin
        opa = 17'(filt);
        opb = 17'(filt);
      end
      mwd_pkg::LOP_RR: begin
        opa = 17'(ref_v);
        opb = 17'(ref_v);
      end
      mwd_pkg::LOP_FR: begin
        opa = 17'(filt);
        opb = 17'(ref_v);
      end
      default: begin
        opa = 17'(a_r);
        opb = 17'(a_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= opa * opb;
    if (cmd.load) begin
      a_r <= accel;
    end
    if (cmd.capture) begin
      filt  <= accel;
      ref_v <= accel;
    end else if (cmd.upd) begin
      filt <= filt_next;
    end
  end

endmodule

// ===== hw/rtl/mwd_merge.sv =====
// ----------------------------------------------------------------------------
// mwd_merge
// Sum lane products and run the wide tilt and shake compares.
// ----------------------------------------------------------------------------
module mwd_merge (
  input  logic                    clk,
  input  mwd_pkg::calc_ctl_t      ctl,
  input  logic signed [33:0]      p0,
  input  logic signed [33:0]      p1,
  input  logic signed [33:0]      p2,
  input  logic        [15:0]      tilt_thr,
  input  logic        [14:0]      shake_thr,
  output mwd_pkg::merge_flags_t   flags
);

  logic signed [35:0] sum;
  logic        [31:0] m2;
  logic        [31:0] c2;
  logic        [31:0] r2;
  logic signed [35:0] dot;
  logic        [31:0] t2;
  logic        [63:0] p1_r;
  logic        [63:0] dd;
  logic        [63:0] pl;
  logic        [63:0] ph;
  logic        [95:0] psum;
  logic        [31:0] hi2;
  logic        [31:0] ma;
  logic        [31:0] mb;
  logic        [63:0] mres;
  logic        [16:0] hi;
  logic        [16:0] lo;
  logic               low_ok;

  assign sum    = 36'(p0) + 36'(p1) + 36'(p2);
  assign hi     = mwd_pkg::ONE_G + 17'(shake_thr);
  assign lo     = mwd_pkg::ONE_G - 17'(shake_thr);
  assign low_ok = 17'(shake_thr) < mwd_pkg::ONE_G;

  always_comb begin
    unique case (ctl.step)
      mwd_pkg::STEP_DOT: begin
        ma = 32'(tilt_thr);
        mb = 32'(tilt_thr);
      end
      mwd_pkg::STEP_RC: begin
        ma = r2;
        mb = c2;
      end
      mwd_pkg::STEP_DD: begin
        ma = dot[31:0];
        mb = dot[31:0];
      end
      mwd_pkg::STEP_PLO: begin
        ma = p1_r[31:0];
        mb = t2;
      end
      mwd_pkg::STEP_PHI: begin
        ma = p1_r[63:32];
        mb = t2;
      end
      mwd_pkg::STEP_HI: begin
        ma = 32'(hi);
        mb = 32'(hi);
      end
      mwd_pkg::STEP_LO: begin
        ma = 32'(lo);
        mb = 32'(lo);
      end
      default: begin
        ma = r2;
        mb = c2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mres <= ma * mb;
    if (ctl.run) begin
      unique case (ctl.step)
        mwd_pkg::STEP_FF:  m2   <= sum[31:0];
        mwd_pkg::STEP_RR:  c2   <= sum[31:0];
        mwd_pkg::STEP_FR:  r2   <= sum[31:0];
        mwd_pkg::STEP_DOT: dot  <= sum;
        mwd_pkg::STEP_RC:  t2   <= mres[31:0];
        mwd_pkg::STEP_DD:  p1_r <= mres;
        mwd_pkg::STEP_PLO: dd   <= mres;
        mwd_pkg::STEP_PHI: pl   <= mres;
        mwd_pkg::STEP_HI:  ph   <= mres;
        mwd_pkg::STEP_LO: begin
          hi2  <= mres[31:0];
          psum <= {ph, 32'b0} + {32'b0, pl};
        end
        default: ;
      endcase
    end
  end

  assign flags.big = (40'(r2) * mwd_pkg::TINY_MUL > mwd_pkg::ONE_G_SQ) &&
                     (40'(c2) * mwd_pkg::TINY_MUL > mwd_pkg::ONE_G_SQ);
  assign flags.tilted = dot[35] || ((tilt_thr != 16'd0) && ({dd, 32'b0} < psum));
  assign flags.dev = (m2 > hi2) || (low_ok && (m2 < mres[31:0]));

endmodule

// ===== hw/rtl/motion_wake_detector.sv =====
// ----------------------------------------------------------------------------
// motion_wake_detector
// Wake a dimmed screen on tilt or shake from timestamped accelerometer polls.
// ----------------------------------------------------------------------------
// Input beats (in_valid/in_ready) carry one poll each; output beats
// (out_valid/out_ready) carry one result per poll: wake, wake_cause, armed_now.
// Configuration is written through cfg_we/cfg_index/cfg_data; write it only while idle (not enforced).
// A poll that stops at gating (sensor off, not armed, too early, failed
// read, reference capture) goes from idle straight to S_DONE.
// A poll that runs the filter and detectors goes through S_CALC: three axis
// lanes share the per-axis products over five steps, then one 32x32
// multiplier builds the wide tilt and shake terms over seven more steps.
// One poll is in flight at a time; in_ready is high only when idle.
// The output register holds a finished result while the receiver stalls;
// the next poll is accepted and worked on meanwhile, and its result waits
// until the held beat is taken.
// Reset clears the arming, timing, reference and counter state and loads the register defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module motion_wake_detector (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               sensor_ok,
  input  logic               dimmed,
  input  logic [31:0]        now_ms,
  input  logic               sample_ok,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               wake,
  output logic [1:0]         wake_cause,
  output logic               armed_now
);

  logic        enable;
  logic [15:0] arm_delay_ms;
  logic [15:0] poll_interval_ms;
  logic [8:0]  filter_alpha;
  logic [15:0] tilt_cos_threshold;
  logic [3:0]  tilt_hold_samples;
  logic [14:0] shake_threshold;
  logic [15:0] shake_window_ms;

  mwd_pkg::state_t state;
  logic [3:0]  step;
  logic        last_dimmed;
  logic        is_armed;
  logic        have_reference;
  logic [31:0] arm_time;
  logic [31:0] last_poll_time;
  logic [31:0] window_start_time;
  logic [3:0]  tilt_count;
  logic [3:0]  shake_count;
  logic [31:0] now_r;
  logic [1:0]  res_cause;
  logic        res_armed;

  logic        in_fire;
  logic        off;
  logic        dim_edge;
  logic        armed_e;
  logic        have_e;
  logic [31:0] arm_time_e;
  logic [31:0] since_arm;
  logic        pass_poll;
  logic        do_capture;
  logic        do_calc;

  logic [8:0]  alpha;
  logic [3:0]  tinc;
  logic        tilt_fire;
  logic        win_reset;
  logic [3:0]  sc_base;
  logic [3:0]  sinc;
  logic        shake_fire;
  logic        deciding;

  mwd_pkg::lane_cmd_t    lcmd;
  mwd_pkg::calc_ctl_t    cctl;
  mwd_pkg::merge_flags_t flags;
  logic signed [33:0]    px;
  logic signed [33:0]    py;
  logic signed [33:0]    pz;

  assign in_ready = (state == mwd_pkg::S_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign off        = !sensor_ok || !enable;
  assign dim_edge   = dimmed != last_dimmed;
  assign armed_e    = dim_edge ? dimmed : is_armed;
  assign have_e     = dim_edge ? 1'b0 : have_reference;
  assign arm_time_e = dim_edge ? now_ms + 32'(arm_delay_ms) : arm_time;
  assign since_arm  = now_ms - arm_time_e;
  assign pass_poll  = dimmed && armed_e && !since_arm[31] &&
                      ((now_ms - last_poll_time) >= 32'(poll_interval_ms));
  assign do_capture = in_fire && !off && pass_poll && sample_ok && !have_e;
  assign do_calc    = !off && pass_poll && sample_ok && have_e;

  assign alpha = (filter_alpha > mwd_pkg::ALPHA_MAX) ? mwd_pkg::ALPHA_MAX : filter_alpha;

  always_comb begin
    lcmd.load    = in_fire;
    lcmd.capture = do_capture;
    lcmd.upd     = (state == mwd_pkg::S_CALC) && (step == mwd_pkg::STEP_AA);
    unique case (step)
      mwd_pkg::STEP_DIFF: lcmd.op = mwd_pkg::LOP_DIFF;
      mwd_pkg::STEP_AA:   lcmd.op = mwd_pkg::LOP_AA;
      mwd_pkg::STEP_FF:   lcmd.op = mwd_pkg::LOP_FF;
      mwd_pkg::STEP_RR:   lcmd.op = mwd_pkg::LOP_RR;
      mwd_pkg::STEP_FR:   lcmd.op = mwd_pkg::LOP_FR;
      default:            lcmd.op = mwd_pkg::LOP_AA;
    endcase
    cctl.run  = (state == mwd_pkg::S_CALC);
    cctl.step = step;
  end

  mwd_lane u_lane_x (.clk(clk), .cmd(lcmd), .accel(accel_x), .alpha(alpha), .prod(px));
  mwd_lane u_lane_y (.clk(clk), .cmd(lcmd), .accel(accel_y), .alpha(alpha), .prod(py));
  mwd_lane u_lane_z (.clk(clk), .cmd(lcmd), .accel(accel_z), .alpha(alpha), .prod(pz));

  mwd_merge u_merge (
    .clk       (clk),
    .ctl       (cctl),
    .p0        (px),
    .p1        (py),
    .p2        (pz),
    .tilt_thr  (tilt_cos_threshold),
    .shake_thr (shake_threshold),
    .flags     (flags)
  );

  assign deciding   = (state == mwd_pkg::S_CALC) && (step == mwd_pkg::STEP_DECIDE);
  assign tinc       = (tilt_count == mwd_pkg::CNT_MAX) ? tilt_count : tilt_count + 4'd1;
  assign tilt_fire  = flags.big && flags.tilted && (tinc >= tilt_hold_samples);
  assign win_reset  = (now_r - window_start_time) > 32'(shake_window_ms);
  assign sc_base    = win_reset ? 4'd0 : shake_count;
  assign sinc       = (sc_base == mwd_pkg::CNT_MAX) ? sc_base : sc_base + 4'd1;
  assign shake_fire = !tilt_fire && flags.dev && (sinc >= mwd_pkg::SHAKE_HITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable             <= 1'b0;
      arm_delay_ms       <= 16'd750;
      poll_interval_ms   <= 16'd50;
      filter_alpha       <= 9'd90;
      tilt_cos_threshold <= 16'd59376;
      tilt_hold_samples  <= 4'd4;
      shake_threshold    <= 15'd1434;
      shake_window_ms    <= 16'd600;
      state              <= mwd_pkg::S_IDLE;
      step               <= 4'd0;
      last_dimmed        <= 1'b0;
      is_armed           <= 1'b0;
      have_reference     <= 1'b0;
      arm_time           <= 32'd0;
      last_poll_time     <= 32'd0;
      window_start_time  <= 32'd0;
      tilt_count         <= 4'd0;
      shake_count        <= 4'd0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mwd_pkg::REG_ENABLE:    enable             <= cfg_data[0];
          mwd_pkg::REG_ARM_DELAY: arm_delay_ms       <= cfg_data;
          mwd_pkg::REG_POLL:      poll_interval_ms   <= cfg_data;
          mwd_pkg::REG_ALPHA:     filter_alpha       <= cfg_data[8:0];
          mwd_pkg::REG_TILT_THR:  tilt_cos_threshold <= cfg_data;
          mwd_pkg::REG_TILT_HOLD: tilt_hold_samples  <= cfg_data[3:0];
          mwd_pkg::REG_SHAKE_THR: shake_threshold    <= cfg_data[14:0];
          mwd_pkg::REG_SHAKE_WIN: shake_window_ms    <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && out_ready && (state != mwd_pkg::S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        mwd_pkg::S_IDLE: begin
          if (in_fire) begin
            now_r     <= now_ms;
            res_cause <= mwd_pkg::CAUSE_NONE;
            step      <= 4'd0;
            state     <= do_calc ? mwd_pkg::S_CALC : mwd_pkg::S_DONE;
            if (off) begin
              last_dimmed <= 1'b0;
              is_armed    <= 1'b0;
              res_armed   <= 1'b0;
            end else begin
              res_armed <= armed_e;
              if (dim_edge) begin
                last_dimmed    <= dimmed;
                is_armed       <= dimmed;
                tilt_count     <= 4'd0;
                shake_count    <= 4'd0;
                arm_time       <= arm_time_e;
              end
              if (pass_poll) begin
                last_poll_time <= now_ms;
              end
              if (do_capture) begin
                have_reference    <= 1'b1;
                window_start_time <= now_ms;
              end else if (dim_edge) begin
                have_reference    <= 1'b0;
              end
            end
          end
        end
        mwd_pkg::S_CALC: begin
          step <= step + 4'd1;
          if (deciding) begin
            state <= mwd_pkg::S_DONE;
            if (flags.big) begin
              tilt_count <= flags.tilted ? tinc : 4'd0;
            end
            if (!tilt_fire) begin
              if (win_reset) begin
                window_start_time <= now_r;
              end
              shake_count <= flags.dev ? sinc : sc_base;
            end
            if (tilt_fire || shake_fire) begin
              is_armed  <= 1'b0;
              res_armed <= 1'b0;
            end
            res_cause <= tilt_fire ? mwd_pkg::CAUSE_TILT :
                         shake_fire ? mwd_pkg::CAUSE_SHAKE : mwd_pkg::CAUSE_NONE;
          end
        end
        mwd_pkg::S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            wake       <= res_cause != mwd_pkg::CAUSE_NONE;
            wake_cause <= res_cause;
            armed_now  <= res_armed;
            state      <= mwd_pkg::S_IDLE;
          end
        end
        default: state <= mwd_pkg::S_IDLE;
      endcase
    end
  end

  `MWD_ASSERT(a_armed_needs_dim, clk, rst, is_armed |-> last_dimmed)
  `MWD_ASSERT(a_wake_matches_cause, clk, rst,
    out_valid |-> (wake == (wake_cause != mwd_pkg::CAUSE_NONE)))
  `MWD_ASSERT(a_wake_disarms, clk, rst, (out_valid && wake) |-> !armed_now)
  `MWD_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> (state == mwd_pkg::S_IDLE))

endmodule
